// ===== rtl/rmws_pkg.sv =====
// shared types, command codes and weight constants of the mesh smoother
`timescale 1ns / 1ps

package rmws_pkg;

  typedef enum logic [1:0] {
    CMD_ADD_NODE = 2'd0,
    CMD_CLOSE    = 2'd1,
    CMD_LOAD     = 2'd2,
    CMD_QUERY    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_SMOOTH_ENABLE   = 2'd0,
    REG_RADIUS          = 2'd1,
    REG_WEIGHT_EXPONENT = 2'd2
  } reg_idx_e;

  localparam int SUM_W    = 40;
  localparam int WEIGHT_W = 17;
  localparam int VSUM_W   = 64;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [9:0]         element_index;
    logic               takes_part;
    logic [9:0]         variable_slot;
    logic signed [31:0] value_in;
  } in_t;

  typedef struct packed {
    logic [9:0]         variable_slot_out;
    logic signed [31:0] smoothed_value;
    logic               status;
  } out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } cent_t;

  // one element's geometry word
  typedef struct packed {
    logic       part;
    logic [9:0] slot;
    cent_t      cent;
  } geom_t;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem  = v;
    root = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // c[k] = 2^(-2^-k) in Q.30
  function automatic logic [29:0] exp_coef(int k);
    logic [63:0] c;
    c = isqrt64(64'h0800_0000_0000_0000);
    for (int i = 1; i < k; i++) begin
      c = isqrt64({c[33:0], 30'd0});
    end
    return c[29:0];
  endfunction

  localparam logic [29:0] EXP_COEF [16] = '{
    exp_coef(1),  exp_coef(2),  exp_coef(3),  exp_coef(4),
    exp_coef(5),  exp_coef(6),  exp_coef(7),  exp_coef(8),
    exp_coef(9),  exp_coef(10), exp_coef(11), exp_coef(12),
    exp_coef(13), exp_coef(14), exp_coef(15), exp_coef(16)
  };

endpackage

// ===== rtl/rmws_store.sv =====
// element geometry and value memories, one read port each, registered read data
`timescale 1ns / 1ps

module rmws_store #(
  parameter int ELEMENTS = 1024,
  parameter int AW       = $clog2(ELEMENTS)
) (
  input  logic               clk_i,
  input  logic               geom_we_i,
  input  logic [AW-1:0]      geom_waddr_i,
  input  rmws_pkg::geom_t    geom_wdata_i,
  input  logic               val_we_i,
  input  logic [AW-1:0]      val_waddr_i,
  input  logic signed [31:0] val_wdata_i,
  input  logic [AW-1:0]      raddr_i,
  output rmws_pkg::geom_t    geom_rdata_o,
  output logic signed [31:0] val_rdata_o
);

  rmws_pkg::geom_t    geom_mem [ELEMENTS];
  logic signed [31:0] val_mem  [ELEMENTS];

  always_ff @(posedge clk_i) begin
    if (geom_we_i) begin
      geom_mem[geom_waddr_i] <= geom_wdata_i;
    end
    geom_rdata_o <= geom_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (val_we_i) begin
      val_mem[val_waddr_i] <= val_wdata_i;
    end
    val_rdata_o <= val_mem[raddr_i];
  end

endmodule

// ===== rtl/rmws_div.sv =====
// iterative unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps

module rmws_div #(
  parameter int DIVISOR_W = 27
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [63:0]          dividend_i,
  input  logic [DIVISOR_W-1:0] divisor_i,
  output logic                 done_o,
  output logic [63:0]          quot_o
);

  logic [63:0]          dq_q;
  logic [DIVISOR_W-1:0] rem_q;
  logic [DIVISOR_W-1:0] div_q;
  logic [5:0]           cnt_q;
  logic                 run_q;
  logic                 done_q;
  logic [DIVISOR_W:0]   rs;
  logic                 ge;

  assign rs = {rem_q, dq_q[63]};
  assign ge = rs >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= ge ? DIVISOR_W'(rs - {1'b0, div_q}) : rs[DIVISOR_W-1:0];
      dq_q  <= {dq_q[62:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

// ===== rtl/rmws_weight.sv =====
// neighbour weight pipeline: distance, square root, ratio, log2 and exp2 stages
`timescale 1ns / 1ps

module rmws_weight (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  rmws_pkg::cent_t    cent_e_i,
  input  rmws_pkg::geom_t    geom_j_i,
  input  logic signed [31:0] value_j_i,
  input  logic [30:0]        radius_i,
  input  logic [61:0]        rr_i,
  input  logic [15:0]        exponent_i,
  output logic               valid_o,
  output logic [16:0]        weight_o,
  output logic signed [31:0] value_o,
  output logic               busy_o
);

  localparam int SqN = 31;
  localparam int DvN = 16;
  localparam int LgN = 16;
  localparam int ExN = 16;

  function automatic logic [32:0] absdiff(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  // stage a: per-axis distances
  logic [32:0]        dd [3];
  logic               far;
  logic               a_v_q;
  logic [30:0]        a_dd_q [3];
  logic signed [31:0] a_val_q;

  always_comb begin
    dd[0] = absdiff(cent_e_i.x, geom_j_i.cent.x);
    dd[1] = absdiff(cent_e_i.y, geom_j_i.cent.y);
    dd[2] = absdiff(cent_e_i.z, geom_j_i.cent.z);
    far   = (dd[0] >= {2'b0, radius_i}) || (dd[1] >= {2'b0, radius_i}) ||
            (dd[2] >= {2'b0, radius_i});
  end

  // stage b: squares
  logic               b_v_q;
  logic [61:0]        b_sq_q [3];
  logic signed [31:0] b_val_q;

  // stage c feeds sqrt slot 0
  logic [63:0] d2;
  assign d2 = 64'(b_sq_q[0]) + 64'(b_sq_q[1]) + 64'(b_sq_q[2]);

  logic [SqN:0]       sq_v_q;
  logic [61:0]        sq_rad_q  [SqN+1];
  logic [32:0]        sq_rem_q  [SqN+1];
  logic [30:0]        sq_root_q [SqN+1];
  logic signed [31:0] sq_val_q  [SqN+1];
  logic [32:0]        sq_rem_d  [SqN];
  logic [30:0]        sq_root_d [SqN];

  always_comb begin
    for (int s = 0; s < SqN; s++) begin
      logic [34:0] rn;
      logic [34:0] tr;
      rn = {sq_rem_q[s], sq_rad_q[s][61:60]};
      tr = {2'b0, sq_root_q[s], 2'b01};
      if (rn >= tr) begin
        sq_rem_d[s]  = 33'(rn - tr);
        sq_root_d[s] = {sq_root_q[s][29:0], 1'b1};
      end else begin
        sq_rem_d[s]  = rn[32:0];
        sq_root_d[s] = {sq_root_q[s][29:0], 1'b0};
      end
    end
  end

  // q = d * 2^16 / r, d below r
  logic [DvN:0]       dv_v_q;
  logic [30:0]        dv_rem_q [DvN+1];
  logic [15:0]        dv_quo_q [DvN+1];
  logic signed [31:0] dv_val_q [DvN+1];
  logic [30:0]        dv_rem_d [DvN];
  logic [15:0]        dv_quo_d [DvN];

  always_comb begin
    for (int s = 0; s < DvN; s++) begin
      logic [31:0] rs;
      logic        ge;
      rs = {dv_rem_q[s], 1'b0};
      ge = rs >= {1'b0, radius_i};
      dv_rem_d[s] = ge ? 31'(rs - {1'b0, radius_i}) : rs[30:0];
      dv_quo_d[s] = {dv_quo_q[s][14:0], ge};
    end
  end

  // log2 of b = 2 - q, one squaring per stage
  logic [LgN:0]       lg_v_q;
  logic               lg_top_q [LgN+1];
  logic [30:0]        lg_x_q   [LgN+1];
  logic [15:0]        lg_l_q   [LgN+1];
  logic signed [31:0] lg_val_q [LgN+1];
  logic [30:0]        lg_x_d   [LgN];
  logic [15:0]        lg_l_d   [LgN];
  logic [16:0]        b_init;

  assign b_init = 17'(18'h20000 - 18'(dv_quo_q[DvN]));

  always_comb begin
    for (int s = 0; s < LgN; s++) begin
      logic [61:0] p;
      p = 62'(lg_x_q[s]) * 62'(lg_x_q[s]);
      lg_x_d[s] = p[61] ? p[61:31] : p[60:30];
      lg_l_d[s] = {lg_l_q[s][14:0], p[61]};
    end
  end

  // exponent product and exp2 by conditional constant multiplies
  logic [16:0] log_full;
  logic [16:0] one_minus;
  logic [32:0] t_prod;

  assign log_full  = lg_top_q[LgN] ? 17'h10000 : {1'b0, lg_l_q[LgN]};
  assign one_minus = 17'h10000 - log_full;
  assign t_prod    = 33'(exponent_i) * 33'(one_minus);

  logic [ExN:0]       ex_v_q;
  logic [30:0]        ex_m_q   [ExN+1];
  logic [8:0]         ex_n_q   [ExN+1];
  logic [15:0]        ex_f_q   [ExN+1];
  logic signed [31:0] ex_val_q [ExN+1];
  logic [30:0]        ex_m_d   [ExN];

  always_comb begin
    for (int s = 0; s < ExN; s++) begin
      logic [60:0] p;
      p = 61'(ex_m_q[s]) * 61'(rmws_pkg::EXP_COEF[s]);
      ex_m_d[s] = ex_f_q[s][15-s] ? p[60:30] : ex_m_q[s];
    end
  end

  logic [9:0]         shamt;
  logic               o_v_q;
  logic [16:0]        o_w_q;
  logic signed [31:0] o_val_q;

  assign shamt = 10'd14 + 10'(ex_n_q[ExN]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q  <= 1'b0;
      b_v_q  <= 1'b0;
      sq_v_q <= '0;
      dv_v_q <= '0;
      lg_v_q <= '0;
      ex_v_q <= '0;
      o_v_q  <= 1'b0;
    end else begin
      a_v_q  <= valid_i && geom_j_i.part && !far;
      b_v_q  <= a_v_q;
      sq_v_q <= {sq_v_q[SqN-1:0], b_v_q && (d2 < 64'(rr_i))};
      dv_v_q <= {dv_v_q[DvN-1:0], sq_v_q[SqN]};
      lg_v_q <= {lg_v_q[LgN-1:0], dv_v_q[DvN]};
      ex_v_q <= {ex_v_q[ExN-1:0], lg_v_q[LgN]};
      o_v_q  <= ex_v_q[ExN];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      a_dd_q[i] <= dd[i][30:0];
      b_sq_q[i] <= 62'(a_dd_q[i]) * 62'(a_dd_q[i]);
    end
    a_val_q <= value_j_i;
    b_val_q <= a_val_q;

    sq_rad_q[0]  <= d2[61:0];
    sq_rem_q[0]  <= '0;
    sq_root_q[0] <= '0;
    sq_val_q[0]  <= b_val_q;
    for (int s = 0; s < SqN; s++) begin
      sq_rad_q[s+1]  <= {sq_rad_q[s][59:0], 2'b00};
      sq_rem_q[s+1]  <= sq_rem_d[s];
      sq_root_q[s+1] <= sq_root_d[s];
      sq_val_q[s+1]  <= sq_val_q[s];
    end

    dv_rem_q[0] <= sq_root_q[SqN];
    dv_quo_q[0] <= '0;
    dv_val_q[0] <= sq_val_q[SqN];
    for (int s = 0; s < DvN; s++) begin
      dv_rem_q[s+1] <= dv_rem_d[s];
      dv_quo_q[s+1] <= dv_quo_d[s];
      dv_val_q[s+1] <= dv_val_q[s];
    end

    lg_top_q[0] <= dv_quo_q[DvN] == 16'd0;
    lg_x_q[0]   <= {b_init, 14'd0};
    lg_l_q[0]   <= '0;
    lg_val_q[0] <= dv_val_q[DvN];
    for (int s = 0; s < LgN; s++) begin
      lg_top_q[s+1] <= lg_top_q[s];
      lg_x_q[s+1]   <= lg_x_d[s];
      lg_l_q[s+1]   <= lg_l_d[s];
      lg_val_q[s+1] <= lg_val_q[s];
    end

    ex_m_q[0]   <= 31'h4000_0000;
    ex_n_q[0]   <= t_prod[32:24];
    ex_f_q[0]   <= t_prod[23:8];
    ex_val_q[0] <= lg_val_q[LgN];
    for (int s = 0; s < ExN; s++) begin
      ex_m_q[s+1]   <= ex_m_d[s];
      ex_n_q[s+1]   <= ex_n_q[s];
      ex_f_q[s+1]   <= ex_f_q[s];
      ex_val_q[s+1] <= ex_val_q[s];
    end

    o_w_q   <= 17'(ex_m_q[ExN] >> shamt);
    o_val_q <= ex_val_q[ExN];
  end

  assign valid_o  = o_v_q;
  assign weight_o = o_w_q;
  assign value_o  = o_val_q;
  assign busy_o   = a_v_q || b_v_q || (|sq_v_q) || (|dv_v_q) || (|lg_v_q) ||
                    (|ex_v_q) || o_v_q;

endmodule

// ===== rtl/mesh_radius_weighted_smoother_top.sv =====
// top level of the mesh radius-weighted smoother
`timescale 1ns / 1ps
// usage:
//   in channel (in_valid_i/in_ready_o/in_data_i) takes one command item at a time:
//   add node, close element, load value or query. only a query gives a result,
//   on the out channel (out_valid_o/out_ready_i/out_data_o).
//   cfg_we_i/cfg_addr_i/cfg_wdata_i write smooth_enable, radius, weight_exponent;
//   write them only while the block is idle.
// timing:
//   add node and load value are done in the idle state; close with nodes runs
//   three 64-step divides by the node count, one bit per cycle in the shared
//   divider, and a query that smooths walks every element: the walk reads one
//   element per cycle from the geometry memory, the weight pipeline is 86 stages
//   deep, then the weighted mean goes through the same shared divider.
//   a query of a non-participating element or with smoothing off skips the walk.
// reset:
//   after reset the geometry memory is swept once to clear participation flags,
//   with in_ready_o low throughout; configuration writes are taken meanwhile.
// stall:
//   the result sits in an output register; the block accepts further items while
//   it waits, and only a new result waits for that register to be taken.

module mesh_radius_weighted_smoother_top #(
  parameter int ELEMENTS       = 1024,
  parameter int MAX_NEIGHBOURS = 1000,
  parameter int MAX_NODES      = 27
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rmws_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rmws_pkg::out_t   out_data_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_addr_i,
  input  logic [30:0]      cfg_wdata_i
);

  localparam int AW     = $clog2(ELEMENTS);
  localparam int CNT_W  = $clog2(MAX_NEIGHBOURS + 1);
  localparam int WSUM_W = rmws_pkg::WEIGHT_W + CNT_W;
  localparam int NODE_W = $clog2(MAX_NODES + 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CDIV, ST_CWAIT, ST_CWRITE, ST_QREAD,
    ST_WALK, ST_DRAIN, ST_FDIV, ST_FWAIT, ST_RESP
  } state_e;

  state_e state_q;

  // configuration
  logic        smooth_en_q;
  logic [30:0] radius_q;
  logic [15:0] exponent_q;
  logic [61:0] rr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_en_q <= 1'b1;
      radius_q    <= 31'd65536;
      exponent_q  <= 16'd256;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        rmws_pkg::REG_SMOOTH_ENABLE:   smooth_en_q <= cfg_wdata_i[0];
        rmws_pkg::REG_RADIUS:          radius_q    <= cfg_wdata_i;
        rmws_pkg::REG_WEIGHT_EXPONENT: exponent_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // squared radius, registered from the radius register
  always_ff @(posedge clk_i) begin
    rr_q <= 62'(radius_q) * 62'(radius_q);
  end

  // item accept and address check
  logic in_acc;
  logic idx_ok;

  assign in_ready_o = state_q == ST_IDLE;
  assign in_acc     = in_valid_i && in_ready_o;
  assign idx_ok     = 32'(in_data_i.element_index) < 32'(ELEMENTS);

  // pending centroid sums
  logic signed [rmws_pkg::SUM_W-1:0] sums_q [3];
  logic [NODE_W-1:0]                 nodes_q;

  // close / query context
  logic [AW-1:0]      tgt_q;
  logic               part_q;
  logic [9:0]         slot_q;
  rmws_pkg::cent_t    cent_q;
  logic [1:0]         axis_q;
  logic [AW-1:0]      ptr_q;
  logic               issue_q;
  rmws_pkg::out_t     res_q;
  rmws_pkg::out_t     out_q;
  logic               out_valid_q;

  // accumulation
  logic                              mul_v_q;
  logic [16:0]                       mul_w_q;
  logic signed [49:0]                mul_q;
  logic [WSUM_W-1:0]                 wsum_q;
  logic signed [rmws_pkg::VSUM_W-1:0] vsum_q;
  logic [CNT_W-1:0]                  count_q;

  // memories
  logic               geom_we;
  logic [AW-1:0]      geom_waddr;
  rmws_pkg::geom_t    geom_wdata;
  logic               val_we;
  logic [AW-1:0]      raddr;
  rmws_pkg::geom_t    geom_rdata;
  logic signed [31:0] val_rdata;

  always_comb begin
    geom_we          = (state_q == ST_CLEAR) || (state_q == ST_CWRITE);
    geom_waddr       = (state_q == ST_CLEAR) ? ptr_q : tgt_q;
    geom_wdata       = '0;
    if (state_q == ST_CWRITE) begin
      geom_wdata.part = part_q;
      geom_wdata.slot = slot_q;
      geom_wdata.cent = cent_q;
    end
    val_we = in_acc && (in_data_i.cmd == rmws_pkg::CMD_LOAD) && idx_ok;
    raddr  = (state_q == ST_IDLE) ? AW'(in_data_i.element_index) : ptr_q;
  end

  rmws_store #(
    .ELEMENTS(ELEMENTS),
    .AW      (AW)
  ) u_store (
    .clk_i       (clk_i),
    .geom_we_i   (geom_we),
    .geom_waddr_i(geom_waddr),
    .geom_wdata_i(geom_wdata),
    .val_we_i    (val_we),
    .val_waddr_i (AW'(in_data_i.element_index)),
    .val_wdata_i (in_data_i.value_in),
    .raddr_i     (raddr),
    .geom_rdata_o(geom_rdata),
    .val_rdata_o (val_rdata)
  );

  // weight pipeline over the walked elements
  logic               w_valid;
  logic [16:0]        w_weight;
  logic signed [31:0] w_value;
  logic               w_busy;

  rmws_weight u_weight (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (issue_q),
    .cent_e_i  (cent_q),
    .geom_j_i  (geom_rdata),
    .value_j_i (val_rdata),
    .radius_i  (radius_q),
    .rr_i      (rr_q),
    .exponent_i(exponent_q),
    .valid_o   (w_valid),
    .weight_o  (w_weight),
    .value_o   (w_value),
    .busy_o    (w_busy)
  );

  // shared divider: centroid on close, weighted mean on query
  logic signed [rmws_pkg::SUM_W-1:0] sum_sel;
  logic [rmws_pkg::SUM_W-1:0]        sum_mag;
  logic [63:0]                       vsum_mag;
  logic                              div_start;
  logic [63:0]                       div_dividend;
  logic [WSUM_W-1:0]                 div_divisor;
  logic                              div_done;
  logic [63:0]                       div_quot;
  logic                              div_neg;
  logic [31:0]                       div_res;

  always_comb begin
    sum_sel  = sums_q[axis_q];
    sum_mag  = sum_sel[rmws_pkg::SUM_W-1] ? rmws_pkg::SUM_W'(-sum_sel)
                                           : rmws_pkg::SUM_W'(sum_sel);
    vsum_mag = vsum_q[63] ? 64'(-vsum_q) : 64'(vsum_q);
    div_start = (state_q == ST_CDIV) || ((state_q == ST_FDIV) && (wsum_q != '0));
    if (state_q == ST_CDIV) begin
      div_dividend = 64'(sum_mag);
      div_divisor  = WSUM_W'(nodes_q);
    end else begin
      div_dividend = vsum_mag;
      div_divisor  = wsum_q;
    end
    div_neg = (state_q == ST_CWAIT) ? sum_sel[rmws_pkg::SUM_W-1] : vsum_q[63];
    div_res = div_neg ? 32'(-div_quot) : div_quot[31:0];
  end

  rmws_div #(
    .DIVISOR_W(WSUM_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // main sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ptr_q       <= '0;
      issue_q     <= 1'b0;
      nodes_q     <= '0;
      for (int i = 0; i < 3; i++) sums_q[i] <= '0;
      axis_q      <= '0;
      tgt_q       <= '0;
      part_q      <= 1'b0;
      slot_q      <= '0;
      cent_q      <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      mul_v_q     <= 1'b0;
      mul_w_q     <= '0;
      mul_q       <= '0;
      wsum_q      <= '0;
      vsum_q      <= '0;
      count_q     <= '0;
    end else begin
      issue_q <= state_q == ST_WALK;

      // two-stage accumulate, capped at the first neighbours in element order
      mul_v_q <= w_valid;
      mul_w_q <= w_weight;
      mul_q   <= $signed({1'b0, w_weight}) * w_value;
      if (mul_v_q && (count_q < CNT_W'(MAX_NEIGHBOURS))) begin
        wsum_q  <= wsum_q + WSUM_W'(mul_w_q);
        vsum_q  <= vsum_q + rmws_pkg::VSUM_W'(mul_q);
        count_q <= count_q + 1'b1;
      end

      // in the response state the output register is handled below
      if (out_valid_q && out_ready_i && (state_q != ST_RESP)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_CLEAR: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == AW'(ELEMENTS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            tgt_q  <= AW'(in_data_i.element_index);
            part_q <= in_data_i.takes_part;
            slot_q <= in_data_i.variable_slot;
            case (in_data_i.cmd)
              rmws_pkg::CMD_ADD_NODE: begin
                if (nodes_q < NODE_W'(MAX_NODES)) begin
                  sums_q[0] <= sums_q[0] + rmws_pkg::SUM_W'(in_data_i.coord_x);
                  sums_q[1] <= sums_q[1] + rmws_pkg::SUM_W'(in_data_i.coord_y);
                  sums_q[2] <= sums_q[2] + rmws_pkg::SUM_W'(in_data_i.coord_z);
                  nodes_q   <= nodes_q + 1'b1;
                end
              end
              rmws_pkg::CMD_CLOSE: begin
                axis_q <= '0;
                cent_q <= '0;
                if (!idx_ok) begin
                  for (int i = 0; i < 3; i++) sums_q[i] <= '0;
                  nodes_q <= '0;
                end else if (nodes_q == '0) begin
                  state_q <= ST_CWRITE;
                end else begin
                  state_q <= ST_CDIV;
                end
              end
              rmws_pkg::CMD_QUERY: begin
                if (!idx_ok) begin
                  res_q   <= '{variable_slot_out: '0, smoothed_value: '0, status: 1'b1};
                  state_q <= ST_RESP;
                end else begin
                  state_q <= ST_QREAD;
                end
              end
              default: ;
            endcase
          end
        end
        ST_CDIV: begin
          state_q <= ST_CWAIT;
        end
        ST_CWAIT: begin
          if (div_done) begin
            case (axis_q)
              2'd0:    cent_q.x <= div_res;
              2'd1:    cent_q.y <= div_res;
              default: cent_q.z <= div_res;
            endcase
            if (axis_q == 2'd2) begin
              state_q <= ST_CWRITE;
            end else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= ST_CDIV;
            end
          end
        end
        ST_CWRITE: begin
          for (int i = 0; i < 3; i++) sums_q[i] <= '0;
          nodes_q <= '0;
          state_q <= ST_IDLE;
        end
        ST_QREAD: begin
          // target element read data is valid here
          cent_q  <= geom_rdata.cent;
          wsum_q  <= '0;
          vsum_q  <= '0;
          count_q <= '0;
          ptr_q   <= '0;
          res_q.variable_slot_out <= geom_rdata.slot;
          // zero radius finds no neighbours, so a smoothed answer is zero
          res_q.smoothed_value    <= (geom_rdata.part && smooth_en_q && (radius_q == '0))
                                     ? '0 : val_rdata;
          res_q.status            <= !geom_rdata.part;
          if (!geom_rdata.part || !smooth_en_q) begin
            state_q <= ST_RESP;
          end else if (radius_q == '0) begin
            state_q <= ST_RESP;
          end else begin
            state_q <= ST_WALK;
          end
        end
        ST_WALK: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == AW'(ELEMENTS - 1)) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!issue_q && !w_busy && !mul_v_q) begin
            state_q <= ST_FDIV;
          end
        end
        ST_FDIV: begin
          if (wsum_q == '0) begin
            res_q.smoothed_value <= '0;
            state_q              <= ST_RESP;
          end else begin
            state_q <= ST_FWAIT;
          end
        end
        ST_FWAIT: begin
          if (div_done) begin
            res_q.smoothed_value <= div_res;
            state_q              <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
